// File: rtl/ria_pkg.sv
// shared constants and types for the rotating id allocator
// op and status codes, id range and the ring control bundle; no dependencies
`timescale 1ns / 1ps

package ria_pkg;

    localparam int NUM_IDS = 254;
    localparam int ID_W    = 8;
    localparam int OP_W    = 2;
    localparam int STS_W   = 2;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTORE = 2'd3;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd2;
    localparam logic [STS_W-1:0] STS_SAME  = 2'd3;

    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
    localparam logic [ID_W-1:0] ID_LAST  = ID_W'(NUM_IDS);

    typedef struct packed {
        logic rotate;
        logic wr_en;
        logic wr_val;
    } ring_ctl_t;

endpackage

// File: rtl/rotating_id_allocator.sv
// rotating id allocator: round-robin handout of ids 1..NUM_IDS
// top level with the op sequencer and result register; depends on ria_pkg, ria_ring
//
// usage:
//   input channel  (in_valid/in_ready):   op, id_in
//   output channel (out_valid/out_ready): id_out, status, one word per input word
//   one word is worked on at a time; in_ready is high only while the sequencer is idle
//   the taken map is a ring of one-bit cells that rotates one place per cycle past a
//   head cell while seeking or scanning; every lookup or update happens at the head
//   after accept, restore or an out-of-range id goes straight to the result;
//   release and reserve first rotate the ring until the id is at the head cell;
//   allocate rotates to the next pointer, then scans at most NUM_IDS cells
//   for a free one, and the next word is taken once the sequencer is idle again
//   the result sits in an output register, so a new word is accepted while the
//   previous result waits; if the receiver stalls, the following result is held
//   inside until the register frees and no further word is taken meanwhile
//   reset clears the whole taken map at once, sets the next pointer to 1 and
//   drops out_valid; the block accepts a word in the first cycle after reset
`timescale 1ns / 1ps

module rotating_id_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ria_pkg::OP_W-1:0]    op,
    input  logic [ria_pkg::ID_W-1:0]    id_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ria_pkg::ID_W-1:0]    id_out,
    output logic [ria_pkg::STS_W-1:0]   status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEEK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0]                  state_reg,     state_next;
    logic [ria_pkg::ID_W-1:0]    ptr_reg,       ptr_next;
    logic                        out_valid_reg, out_valid_next;
    logic [ria_pkg::OP_W-1:0]    op_reg,        op_next;
    logic [ria_pkg::ID_W-1:0]    tgt_reg,       tgt_next;
    logic [ria_pkg::ID_W-1:0]    cnt_reg,       cnt_next;
    logic [ria_pkg::ID_W-1:0]    res_id_reg,    res_id_next;
    logic [ria_pkg::STS_W-1:0]   res_st_reg,    res_st_next;
    logic [ria_pkg::ID_W-1:0]    id_out_reg,    id_out_next;
    logic [ria_pkg::STS_W-1:0]   status_reg,    status_next;

    ria_pkg::ring_ctl_t          ring_ctl;
    logic [ria_pkg::ID_W-1:0]    head_id;
    logic                        head_taken;
    logic                        id_ok;
    logic                        out_free;

    ria_ring u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ring_ctl),
        .head_id    (head_id),
        .head_taken (head_taken)
    );

    assign id_ok    = (id_in >= ria_pkg::ID_FIRST) && (id_in <= ria_pkg::ID_LAST);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        tgt_next       = tgt_reg;
        cnt_next       = cnt_reg;
        res_id_next    = res_id_reg;
        res_st_next    = res_st_reg;
        id_out_next    = id_out_reg;
        status_next    = status_reg;
        ring_ctl       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    res_id_next = '0;
                    res_st_next = ria_pkg::STS_OK;
                    case (op)
                        ria_pkg::OP_ALLOC:
                        begin
                            tgt_next   = ptr_reg;
                            state_next = S_SEEK;
                        end
                        ria_pkg::OP_RELEASE, ria_pkg::OP_RESERVE:
                        begin
                            if (id_ok)
                            begin
                                tgt_next   = id_in;
                                state_next = S_SEEK;
                            end
                            else
                            begin
                                res_st_next = ria_pkg::STS_RANGE;
                                state_next  = S_RESP;
                            end
                        end
                        default:
                        begin
                            ptr_next   = id_ok ? id_in : ria_pkg::ID_FIRST;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SEEK:
            begin
                if (head_id == tgt_reg)
                begin
                    if (op_reg == ria_pkg::OP_ALLOC)
                    begin
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        // release wants a taken bit, reserve wants a free one
                        if (head_taken == (op_reg == ria_pkg::OP_RELEASE))
                        begin
                            ring_ctl.wr_en  = 1'b1;
                            ring_ctl.wr_val = (op_reg == ria_pkg::OP_RESERVE);
                        end
                        else
                        begin
                            res_st_next = ria_pkg::STS_SAME;
                        end
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    ring_ctl.rotate = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (!head_taken)
                begin
                    ring_ctl.wr_en  = 1'b1;
                    ring_ctl.wr_val = 1'b1;
                    res_id_next     = head_id;
                    ptr_next        = (head_id == ria_pkg::ID_LAST) ? ria_pkg::ID_FIRST
                                                                    : head_id + ria_pkg::ID_FIRST;
                    state_next      = S_RESP;
                end
                else if (cnt_reg == ria_pkg::ID_W'(ria_pkg::NUM_IDS - 1))
                begin
                    res_st_next = ria_pkg::STS_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    ring_ctl.rotate = 1'b1;
                    cnt_next        = cnt_reg + ria_pkg::ID_FIRST;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    id_out_next    = res_id_reg;
                    status_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= ria_pkg::ID_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        tgt_reg    <= tgt_next;
        cnt_reg    <= cnt_next;
        res_id_reg <= res_id_next;
        res_st_reg <= res_st_next;
        id_out_reg <= id_out_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign id_out    = id_out_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg >= ria_pkg::ID_FIRST) && (ptr_reg <= ria_pkg::ID_LAST))
        else $error("next pointer left the id range");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_id >= ria_pkg::ID_FIRST) && (head_id <= ria_pkg::ID_LAST))
        else $error("head cell id left the id range");

    a_no_rotate_write: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.rotate |-> !ring_ctl.wr_en)
        else $error("ring rotated and written in the same cycle");

    a_id_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (id_out != '0)) |-> (status == ria_pkg::STS_OK))
        else $error("id handed out with a failing status");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_valid_reg && !out_ready) |=> (state_reg == S_RESP))
        else $error("result dropped while the output register was full");
`endif

endmodule

// File: rtl/ria_cell.sv
// one cell of the taken-map ring: holds the taken bit of one id
// shifts from its neighbor on rotate, head cell also takes writes; uses no package
`timescale 1ns / 1ps

module ria_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic shift_en,
    input  logic nbr_in,
    input  logic wr_en,
    input  logic wr_val,
    output logic taken
);

    logic taken_reg;
    logic taken_next;

    always_comb
    begin
        taken_next = taken_reg;
        if (shift_en)
        begin
            taken_next = nbr_in;
        end
        else if (wr_en)
        begin
            taken_next = wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
        end
        else
        begin
            taken_reg <= taken_next;
        end
    end

    assign taken = taken_reg;

endmodule

// File: rtl/ria_ring.sv
// ring of taken-map cells that rotates past a fixed head cell
// tracks which id sits in the head cell; depends on ria_pkg and ria_cell
`timescale 1ns / 1ps

module ria_ring (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ria_pkg::ring_ctl_t        ctl,
    output logic [ria_pkg::ID_W-1:0]  head_id,
    output logic                      head_taken
);

    logic [ria_pkg::NUM_IDS-1:0] cell_q;
    logic [ria_pkg::ID_W-1:0]    head_id_reg;
    logic [ria_pkg::ID_W-1:0]    head_id_next;

    // cell k holds the id k places after the head, wrapping round
    genvar k;
    generate
        for (k = 0; k < ria_pkg::NUM_IDS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                ria_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (ctl.rotate),
                    .nbr_in   (cell_q[(k + 1) % ria_pkg::NUM_IDS]),
                    .wr_en    (ctl.wr_en),
                    .wr_val   (ctl.wr_val),
                    .taken    (cell_q[k])
                );
            end
            else
            begin : g_body
                ria_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (ctl.rotate),
                    .nbr_in   (cell_q[(k + 1) % ria_pkg::NUM_IDS]),
                    .wr_en    (1'b0),
                    .wr_val   (1'b0),
                    .taken    (cell_q[k])
                );
            end
        end
    endgenerate

    always_comb
    begin
        head_id_next = head_id_reg;
        if (ctl.rotate)
        begin
            head_id_next = (head_id_reg == ria_pkg::ID_LAST) ? ria_pkg::ID_FIRST
                                                             : head_id_reg + ria_pkg::ID_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_id_reg <= ria_pkg::ID_FIRST;
        end
        else
        begin
            head_id_reg <= head_id_next;
        end
    end

    assign head_id    = head_id_reg;
    assign head_taken = cell_q[0];

endmodule
